>>> src/rcpwm_pkg.sv
// Shared types, constants and helper functions for the RC PWM setpoint decoder.
package rcpwm_pkg;

   localparam int CHANNELS   = 6;
   localparam int WIDTH_BITS = 12;
   localparam int MAX_CH     = 8;
   localparam int PIN_BITS   = 6;
   localparam int TIME_BITS  = 32;
   localparam int LEVEL_BITS = 12;
   localparam int OFS_BITS   = 10;
   localparam int CDEG_BITS  = 16;
   localparam int CORR_BITS  = WIDTH_BITS + 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 12;
   localparam int REQ_BITS  = 40;
   localparam int RSP_BITS  = 96;

   localparam logic [TIME_BITS-1:0] WIDTH_MAX = TIME_BITS'((64'd1 << WIDTH_BITS) - 64'd1);
   localparam int LEVEL_MAX = 4095;
   localparam logic signed [CDEG_BITS-1:0] CDEG_BIAS = 16'sd12000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ROLL_OFS     = 3'd0,
      REG_PITCH_OFS    = 3'd1,
      REG_THROTTLE_OFS = 3'd2,
      REG_YAW_OFS      = 3'd3,
      REG_DB_LOW       = 3'd4,
      REG_DB_HIGH      = 3'd5,
      REG_YAW_THR_MIN  = 3'd6
   } csr_index_type;

   typedef logic [WIDTH_BITS-1:0] width_type;

   // One decoded sample: stored widths after this sample and the falling-edge flags.
   typedef struct packed {
      logic [MAX_CH-1:0][WIDTH_BITS-1:0] width;
      logic [MAX_CH-1:0]                 done;
   } chan_entry_type;

   // Width plus signed correction, clamped to 0..4095.
   function automatic logic [LEVEL_BITS-1:0] corrected(input width_type w,
                                                     input logic signed [OFS_BITS-1:0] off);
      logic signed [CORR_BITS-1:0] v;
      logic [LEVEL_BITS-1:0]       r;
      v = signed'({2'b00, w}) + CORR_BITS'(off);
      if (v < 0) begin
         r = '0;
      end else if (v > CORR_BITS'(LEVEL_MAX)) begin
         r = LEVEL_BITS'(LEVEL_MAX);
      end else begin
         r = LEVEL_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] sat_level(input width_type w);
      logic [LEVEL_BITS-1:0] r;
      if (32'(w) > 32'(LEVEL_MAX)) begin
         r = LEVEL_BITS'(LEVEL_MAX);
      end else begin
         r = LEVEL_BITS'(w);
      end
      return r;
   endfunction

endpackage

>>> src/rcpwm_front.sv
// Front end: pin edge detection, rise timestamps and pulse width capture.
module rcpwm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [rcpwm_pkg::PIN_BITS-1:0]    pin_levels,
   input  logic [rcpwm_pkg::TIME_BITS-1:0]   time_us,
   output logic                              push,
   output rcpwm_pkg::chan_entry_type         push_entry,
   input  logic                              q_full
);
   import rcpwm_pkg::*;

   logic [MAX_CH-1:0]                 level_ff, level_in;
   logic [MAX_CH-1:0][TIME_BITS-1:0]  rise_ff, rise_in;
   logic [MAX_CH-1:0][WIDTH_BITS-1:0] width_ff, width_in;
   logic [MAX_CH-1:0]                 done;
   logic [TIME_BITS-1:0]              delta [MAX_CH];

   assign in_ready = !q_full;
   assign push     = in_valid && !q_full;

   always_comb begin
      level_in = level_ff;
      rise_in  = rise_ff;
      width_in = width_ff;
      done     = '0;
      for (int i = 0; i < MAX_CH; i++) begin
         delta[i] = time_us - rise_ff[i];
         if (i < CHANNELS) begin
            if ((i < PIN_BITS) && pin_levels[i % PIN_BITS]) begin
               if (!level_ff[i]) begin
                  level_in[i] = 1'b1;
                  rise_in[i]  = time_us;
               end
            end else if (level_ff[i]) begin
               level_in[i] = 1'b0;
               width_in[i] = (delta[i] > WIDTH_MAX) ? WIDTH_BITS'(WIDTH_MAX)
                                                    : WIDTH_BITS'(delta[i]);
               done[i]     = 1'b1;
            end
         end
      end
      push_entry.width = width_in;
      push_entry.done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         rise_ff  <= '0;
         width_ff <= '0;
      end else if (push) begin
         level_ff <= level_in;
         rise_ff  <= rise_in;
         width_ff <= width_in;
      end
   end

endmodule

>>> src/rcpwm_queue.sv
// Two-entry queue between the capture front end and the mapping back end.
module rcpwm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rcpwm_pkg::chan_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      q_valid,
   output rcpwm_pkg::chan_entry_type head
);
   import rcpwm_pkg::*;

   chan_entry_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/rcpwm_back.sv
// Back end: control registers, width correction, setpoint mapping and output register.
module rcpwm_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [rcpwm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rcpwm_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                 q_valid,
   input  rcpwm_pkg::chan_entry_type            head,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rcpwm_pkg::RSP_BITS-1:0]       rsp_tdata
);
   import rcpwm_pkg::*;

   logic signed [OFS_BITS-1:0] roll_ofs_ff, pitch_ofs_ff, thr_ofs_ff, yaw_ofs_ff;
   logic [LEVEL_BITS-1:0]      db_low_ff, db_high_ff, yaw_thr_min_ff;
   logic                       valid_ff, valid_in;
   logic [RSP_BITS-1:0]        data_ff, data_in;

   logic [LEVEL_BITS-1:0]         r, p, t, y, a1, a2;
   logic signed [CDEG_BITS-1:0]   roll, pitch, yaw;
   logic                          r_db, p_db, y_db;
   logic [PIN_BITS-1:0]           done;

   assign pop        = q_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ofs_ff    <= '0;
         pitch_ofs_ff   <= '0;
         thr_ofs_ff     <= '0;
         yaw_ofs_ff     <= 10'sd9;
         db_low_ff      <= 12'd1490;
         db_high_ff     <= 12'd1510;
         yaw_thr_min_ff <= 12'd1050;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ROLL_OFS:     roll_ofs_ff    <= signed'(csr_data[OFS_BITS-1:0]);
            REG_PITCH_OFS:    pitch_ofs_ff   <= signed'(csr_data[OFS_BITS-1:0]);
            REG_THROTTLE_OFS: thr_ofs_ff     <= signed'(csr_data[OFS_BITS-1:0]);
            REG_YAW_OFS:      yaw_ofs_ff     <= signed'(csr_data[OFS_BITS-1:0]);
            REG_DB_LOW:       db_low_ff      <= csr_data;
            REG_DB_HIGH:      db_high_ff     <= csr_data;
            REG_YAW_THR_MIN:  yaw_thr_min_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      r  = corrected(head.width[0], roll_ofs_ff);
      p  = corrected(head.width[1], pitch_ofs_ff);
      t  = corrected(head.width[2], thr_ofs_ff);
      y  = corrected(head.width[3], yaw_ofs_ff);
      a1 = sat_level(head.width[4]);
      a2 = sat_level(head.width[5]);
      r_db = (r >= db_low_ff) && (r <= db_high_ff);
      p_db = (p >= db_low_ff) && (p <= db_high_ff);
      y_db = (y >= db_low_ff) && (y <= db_high_ff);
      roll  = r_db ? '0 : signed'({1'b0, r, 3'b000}) - CDEG_BIAS;
      pitch = p_db ? '0 : signed'({1'b0, p, 3'b000}) - CDEG_BIAS;
      yaw   = (y_db || !(t > yaw_thr_min_ff)) ? '0
              : CDEG_BIAS - signed'({1'b0, y, 3'b000});
      done  = head.done[PIN_BITS-1:0];
      data_in = {6'd0, done, a2, a1, t, yaw, pitch, roll};
      valid_in = pop ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> src/rc_pwm_capture_setpoints.sv
// RC receiver pulse width decoder producing roll, pitch and yaw setpoints.
// Path: an accepted request is stored in the queue, then mapped into the output register.
// Throughput: one request per cycle while the queue is not full; a 2-entry queue decouples capture from mapping.
// Reset: synchronous active-high; clears levels, rise times, widths, queue and output,
// and loads control registers with their defaults.
module rc_pwm_capture_setpoints (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [5:0] pin_levels, [37:6] time_us, [39:38] zero
   input  logic [rcpwm_pkg::REQ_BITS-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] roll_cdeg, [31:16] pitch_cdeg, [47:32] yaw_cdeg, [59:48] throttle_level,
   // [71:60] aux_one_width, [83:72] aux_two_width, [89:84] pulse_done, [95:90] zero
   output logic [rcpwm_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rcpwm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rcpwm_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rcpwm_pkg::*;

   logic           push, q_full, pop, q_valid;
   chan_entry_type push_entry, head;

   assign csr_ready = 1'b1;

   rcpwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .pin_levels (req_tdata[PIN_BITS-1:0]),
      .time_us    (req_tdata[PIN_BITS+TIME_BITS-1:PIN_BITS]),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   rcpwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .head       (head)
   );

   rcpwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/rc_pwm_capture_setpoints_tb.sv
// Self-checking testbench for the RC PWM capture and setpoint decoder.
module rc_pwm_capture_setpoints_tb;
   import rcpwm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic [5:0]         pad;
      logic [5:0]         done_mask;
      logic [11:0]        aux_two;
      logic [11:0]        aux_one;
      logic [11:0]        throttle;
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } setpoint_word_type;

   class setpoint_scoreboard;
      logic signed [9:0] ofs [4];
      logic [11:0]       db_low, db_high, yaw_min;
      logic [5:0]        level_seen;
      logic [31:0]       rise_at [6];
      logic [11:0]       width [6];
      setpoint_word_type expected_q [$];
      int                errors;

      function new();
         ofs[0] = 0;
         ofs[1] = 0;
         ofs[2] = 0;
         ofs[3] = 9;
         db_low = 12'd1490;
         db_high = 12'd1510;
         yaw_min = 12'd1050;
         level_seen = '0;
         for (int i = 0; i < 6; i++) begin
            rise_at[i] = '0;
            width[i] = '0;
         end
         errors = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [11:0] value);
         case (idx)
            REG_ROLL_OFS:     ofs[0] = value[9:0];
            REG_PITCH_OFS:    ofs[1] = value[9:0];
            REG_THROTTLE_OFS: ofs[2] = value[9:0];
            REG_YAW_OFS:      ofs[3] = value[9:0];
            REG_DB_LOW:       db_low = value;
            REG_DB_HIGH:      db_high = value;
            REG_YAW_THR_MIN:  yaw_min = value;
            default: ;
         endcase
      endfunction

      // stored width plus offset, clamped to 0..4095
      function int level_of(int ch);
         int v;
         v = int'(width[ch]) + int'(ofs[ch]);
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         return v;
      endfunction

      function bit in_zero_zone(int v);
         return v >= int'(db_low) && v <= int'(db_high);
      endfunction

      function void note_request(logic [5:0] pins, logic [31:0] now_us);
         setpoint_word_type e;
         logic [31:0]       w;
         int                r, p, t, y;
         e = '0;
         for (int i = 0; i < 6; i++) begin
            if (pins[i]) begin
               if (!level_seen[i]) begin
                  level_seen[i] = 1'b1;
                  rise_at[i] = now_us;
               end
            end else if (level_seen[i]) begin
               w = now_us - rise_at[i];
               level_seen[i] = 1'b0;
               width[i] = (w > 32'd4095) ? 12'hFFF : w[11:0];
               e.done_mask[i] = 1'b1;
            end
         end
         r = level_of(0);
         p = level_of(1);
         t = level_of(2);
         y = level_of(3);
         e.roll = in_zero_zone(r) ? 16'sd0 : 16'(-4000 + (r - 1000) * 8);
         e.pitch = in_zero_zone(p) ? 16'sd0 : 16'(-4000 + (p - 1000) * 8);
         e.yaw = (in_zero_zone(y) || t <= int'(yaw_min)) ? 16'sd0
                 : 16'(4000 - (y - 1000) * 8);
         e.throttle = 12'(t);
         e.aux_one = width[4];
         e.aux_two = width[5];
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_response(logic [RSP_BITS-1:0] data);
         setpoint_word_type got, e;
         got = data;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, actual %h", $time, data);
            return;
         end
         e = expected_q.pop_front();
         compare_field("roll_cdeg", e.roll, got.roll);
         compare_field("pitch_cdeg", e.pitch, got.pitch);
         compare_field("yaw_cdeg", e.yaw, got.yaw);
         compare_field("throttle_level", e.throttle, got.throttle);
         compare_field("aux_one_width", e.aux_one, got.aux_one);
         compare_field("aux_two_width", e.aux_two, got.aux_two);
         compare_field("pulse_done", e.done_mask, got.done_mask);
         compare_field("pad", e.pad, got.pad);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   setpoint_scoreboard sb;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   bit                 steady_sender = 1'b0;
   bit                 hold_request = 1'b0;

   // stimulus-side pulse planner
   logic [31:0]       now_track;
   logic [5:0]        pin_state;
   logic [31:0]       plan_rise [6];
   logic [31:0]       plan_len [6];
   logic signed [9:0] cfg_ofs [4];
   logic [11:0]       cfg_db_low, cfg_db_high, cfg_yaw_min;

   rc_pwm_capture_setpoints u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: check accepted results, then pick the next ready value
   initial begin
      int  mode;
      int  mode_left;
      int  hold_left;
      int  tick;
      logic nxt;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            nxt = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(32, 200);
            end else begin
               mode_left--;
            end
            case (mode)
               0: nxt = 1'b1;
               1: nxt = 1'($urandom_range(0, 1));
               2: nxt = (tick % 4) != 0;
               default: nxt = ($urandom_range(0, 4) == 0);
            endcase
         end
         rsp_tready <= nxt;
      end
   end

   task automatic send_sample(input logic [5:0] pins, input logic [31:0] now_us);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, now_us, pins};
      do @(posedge clock); while (!req_tready);
      sb.note_request(pins, now_us);
      if (burst_left > 0) begin
         burst_left--;
      end else if (!steady_sender) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, value);
   endtask

   task automatic apply_settings();
      write_register(REG_ROLL_OFS, {2'b00, cfg_ofs[0]});
      write_register(REG_PITCH_OFS, {2'b00, cfg_ofs[1]});
      write_register(REG_THROTTLE_OFS, {2'b00, cfg_ofs[2]});
      write_register(REG_YAW_OFS, {2'b00, cfg_ofs[3]});
      write_register(REG_DB_LOW, cfg_db_low);
      write_register(REG_DB_HIGH, cfg_db_high);
      write_register(REG_YAW_THR_MIN, cfg_yaw_min);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic choose_settings(input int ph);
      for (int i = 0; i < 4; i++) begin
         case (ph)
            1: cfg_ofs[i] = -10'sd512;
            2: cfg_ofs[i] = 10'sd511;
            3, 6: cfg_ofs[i] = 10'($urandom_range(0, 127) - 64);
            default: cfg_ofs[i] = 10'($urandom_range(0, 1023));
         endcase
      end
      case (ph)
         1: begin
            cfg_db_low = 12'd0;
            cfg_db_high = 12'd0;
            cfg_yaw_min = 12'd0;
         end
         2: begin
            cfg_db_low = 12'd4095;
            cfg_db_high = 12'd4095;
            cfg_yaw_min = 12'd4095;
         end
         3: begin
            cfg_db_low = 12'd1600;
            cfg_db_high = 12'd1400;
            cfg_yaw_min = 12'($urandom_range(0, 2000));
         end
         5: begin
            cfg_db_low = 12'd0;
            cfg_db_high = 12'd4095;
            cfg_yaw_min = 12'($urandom_range(0, 4095));
         end
         default: begin
            cfg_db_low = 12'($urandom_range(1400, 1550));
            cfg_db_high = cfg_db_low + 12'($urandom_range(0, 80));
            cfg_yaw_min = 12'($urandom_range(900, 1300));
         end
      endcase
   endtask

   // mostly plausible receiver frames; one sample in ten is noise
   task automatic make_sample(output logic [5:0] pins, output logic [31:0] stamp);
      logic [31:0] step;
      if ($urandom_range(0, 9) == 0) begin
         pin_state = 6'($urandom);
         now_track = $urandom;
         for (int i = 0; i < 6; i++) begin
            if (pin_state[i]) begin
               plan_rise[i] = now_track;
               plan_len[i] = $urandom_range(0, 3000);
            end
         end
      end else begin
         step = ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, 150);
         now_track += step;
         for (int i = 0; i < 6; i++) begin
            if (pin_state[i]) begin
               if (now_track - plan_rise[i] >= plan_len[i]) pin_state[i] = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               pin_state[i] = 1'b1;
               plan_rise[i] = now_track;
               case ($urandom_range(0, 9))
                  0: plan_len[i] = $urandom_range(0, 4095);
                  1: plan_len[i] = $urandom_range(4096, 20000);
                  default: plan_len[i] = $urandom_range(900, 2200);
               endcase
            end
         end
      end
      pins = pin_state;
      stamp = now_track;
   endtask

   initial begin
      logic [31:0] base;
      logic [5:0]  pins;
      logic [31:0] stamp;
      int          count;
      sb = new();
      now_track = $urandom;
      pin_state = '0;
      for (int i = 0; i < 6; i++) begin
         plan_rise[i] = '0;
         plan_len[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 7; ph++) begin
         if (ph > 0) begin
            choose_settings(ph);
            apply_settings();
         end
         if (ph == 1 || ph == 4 || ph == 6) hold_request = 1'b1;
         count = 110;
         if (ph == 0) begin
            // reset settings: wrap, saturation, deadband edges, throttle gate
            base = 32'hFFFF_FC00;
            send_sample(6'h00, 32'd0);
            send_sample(6'h3F, base);
            send_sample(6'h3E, base + 32'd1000);
            send_sample(6'h3C, base + 32'd2000);
            send_sample(6'h38, base + 32'd2100);
            send_sample(6'h30, base + 32'd2509);
            send_sample(6'h00, base + 32'd9000);
            send_sample(6'h01, 32'd1000);
            send_sample(6'h00, 32'd2495);
            send_sample(6'h0A, 32'd5000);
            send_sample(6'h00, 32'd6490);
            send_sample(6'h04, 32'd10000);
            send_sample(6'h00, 32'd11050);
            send_sample(6'h08, 32'd20000);
            send_sample(6'h00, 32'd21800);
            send_sample(6'h04, 32'd30000);
            send_sample(6'h00, 32'd31051);
            send_sample(6'h3F, 32'hFFFF_FFFF);
            send_sample(6'h3F, 32'd0);
            send_sample(6'h00, 32'd1);
            send_sample(6'h01, 32'd5);
            send_sample(6'h00, 32'd5);
            count = 90;
         end
         for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) steady_sender = ($urandom_range(0, 3) == 0);
            make_sample(pins, stamp);
            send_sample(pins, stamp);
         end
         req_tvalid <= 1'b0;
         while (sb.expected_q.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> rc_pwm_capture_setpoints.f
src/rcpwm_pkg.sv
src/rcpwm_front.sv
src/rcpwm_queue.sv
src/rcpwm_back.sv
src/rc_pwm_capture_setpoints.sv
tb/sv/rc_pwm_capture_setpoints_tb.sv
